// ===== sv/vdh_pkg.sv =====
`default_nettype none

package vdh_pkg;

    localparam int BIN_COUNT = 40;
    localparam int BIN_W     = $clog2(BIN_COUNT);
    localparam int RAM_DEPTH = 3 * BIN_COUNT;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam int DIV_DW = 40;     // dividend / quotient width
    localparam int DIV_SW = 24;     // divisor width

    localparam logic [23:0] SAT24 = 24'hFFFFFF;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] CFG_WIRING  = 2'd0;
    localparam logic [1:0] CFG_THRESH  = 2'd1;
    localparam logic [1:0] CFG_NOMINAL = 2'd2;

    localparam logic [31:0] NOMINAL_RST = 32'd812800;

    // deviation bin from the low quotient byte, folded about 100
    function automatic logic [BIN_W-1:0] bin_of(input logic [7:0] q);
        int h;
        int qi;
        int d;
        int b;
        h  = BIN_COUNT / 2;
        qi = int'(q);
        if (qi > 100) begin
            d = qi - 100;
            if (d > h) d = h - 1;
            b = h - d;
        end else if (qi < 100) begin
            d = 100 - qi;
            b = (d > h) ? h - 1 : h + d;
        end else begin
            b = h;
        end
        if (b < 0 || b >= BIN_COUNT) b = 0;
        return BIN_W'(b);
    endfunction

endpackage

`default_nettype wire

// ===== sv/vdh_ram.sv =====
`default_nettype none

module vdh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 120
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/vdh_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module vdh_div
    import vdh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_DW-1:0] dividend,
    input  wire logic [DIV_SW-1:0] divisor,
    output logic                   done,
    output logic      [DIV_DW-1:0] quotient
);

    localparam int CW = $clog2(DIV_DW + 1);

    logic [DIV_DW-1:0] dq_reg;
    logic [DIV_SW-1:0] rem_reg;
    logic [DIV_SW-1:0] dvs_reg;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;
    logic [DIV_SW:0]   trial;
    logic              fits;

    assign trial = {rem_reg, dq_reg[DIV_DW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(DIV_DW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? DIV_SW'(trial - {1'b0, dvs_reg}) : DIV_SW'(trial);
            dq_reg  <= {dq_reg[DIV_DW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

`default_nettype wire

// ===== sv/voltage_deviation_histogram_stats.sv =====
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       in         in_valid/in_stall    kind, phase_sel, volt_r..volt_rt
// out      out        out_valid/out_stall  is_summary, min/mean/max, faults, bin_*, last
// cfg      in         cfg_we               cfg_index, cfg_data
//
// A sample visits the three phases in turn. Each phase above threshold
// passes the threshold check, waits on the 40-step shared serial divider
// and does the histogram RAM write-back; a fault phase ends at the check.
// A report waits on the divider for the mean (not if the count is zero),
// then sends the summary and each bin in turn (RAM read, output load), held by out_stall.
// Clear and ignored items leave the sequencer idle. in_stall is high while busy.
// Reset clears statistics and histogram valid bits at once; no sweep.
module voltage_deviation_histogram_stats
    import vdh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [1:0]  phase_sel,
    input  wire logic [15:0] volt_r,
    input  wire logic [15:0] volt_s,
    input  wire logic [15:0] volt_t,
    input  wire logic [15:0] volt_rs,
    input  wire logic [15:0] volt_st,
    input  wire logic [15:0] volt_rt,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             is_summary,
    output logic      [15:0] min_volt,
    output logic      [15:0] mean_volt,
    output logic      [15:0] max_volt,
    output logic      [23:0] faults,
    output logic      [5:0]  bin_index,
    output logic      [23:0] bin_value,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHK   = 3'd1;  // sample: fault or start divide
    localparam logic [2:0] ST_DIV   = 3'd2;  // sample: wait quotient, read bin
    localparam logic [2:0] ST_WR    = 3'd3;  // sample: bin write-back
    localparam logic [2:0] ST_MEAN  = 3'd4;  // report: wait mean
    localparam logic [2:0] ST_SUM   = 3'd5;  // report: summary transfer
    localparam logic [2:0] ST_BRD   = 3'd6;  // report: bin read
    localparam logic [2:0] ST_BLD   = 3'd7;  // report: bin transfer

    logic [2:0]  state_reg;
    logic [1:0]  ph_reg;
    logic [BIN_W-1:0] idx_reg;
    logic [RAM_AW-1:0] addr_reg;

    logic        wiring_reg;
    logic [15:0] thr_reg;
    logic [31:0] nom_reg;

    logic [15:0] vs_reg [3];
    logic [15:0] min_reg [3];
    logic [15:0] max_reg [3];
    logic [39:0] sum_reg [3];
    logic [23:0] cnt_reg [3];
    logic [23:0] flt_reg [3];
    logic [RAM_DEPTH-1:0] vld_reg;
    logic [15:0] mean_reg;

    logic        out_valid_reg;
    logic        is_summary_reg;
    logic [15:0] min_out_reg;
    logic [15:0] mean_out_reg;
    logic [15:0] max_out_reg;
    logic [23:0] faults_out_reg;
    logic [5:0]  bin_index_reg;
    logic [23:0] bin_value_reg;
    logic        last_reg;

    logic        accept;
    logic        slot_free;
    logic [15:0] st_v [3];
    logic [15:0] cur_v;
    logic        div_start;
    logic [DIV_DW-1:0] div_dvd;
    logic [DIV_SW-1:0] div_dvs;
    logic        div_done;
    logic [DIV_DW-1:0] div_quo;
    logic        ram_rd;
    logic [RAM_AW-1:0] ram_rd_addr;
    logic        ram_wr;
    logic [23:0] ram_q;
    logic [23:0] bin_cur;
    logic [23:0] bin_inc;
    logic [RAM_AW-1:0] ph_base;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != ST_IDLE;
    assign slot_free = !out_valid_reg || !out_stall;
    assign cur_v     = vs_reg[ph_reg];
    assign ph_base   = RAM_AW'(ph_reg) * RAM_AW'(BIN_COUNT);
    assign bin_cur   = vld_reg[addr_reg] ? ram_q : 24'd0;
    assign bin_inc   = (bin_cur == SAT24) ? bin_cur : bin_cur + 24'd1;

    assign st_v[0] = wiring_reg ? volt_rs : volt_r;
    assign st_v[1] = wiring_reg ? volt_st : volt_s;
    assign st_v[2] = wiring_reg ? volt_rt : volt_t;

    // shared divider: bin quotient on samples, mean on reports
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = {8'd0, nom_reg};
        div_dvs   = {8'd0, cur_v};
        if (state_reg == ST_CHK) begin
            div_start = cur_v > thr_reg;
        end else if (accept && kind == KIND_REPORT && phase_sel != 2'd3) begin
            div_start = cnt_reg[phase_sel] != 24'd0;
            div_dvd   = sum_reg[phase_sel];
            div_dvs   = cnt_reg[phase_sel];
        end
    end

    always_comb
    begin
        ram_rd      = 1'b0;
        ram_rd_addr = ph_base + RAM_AW'(idx_reg);
        if (state_reg == ST_DIV && div_done) begin
            ram_rd      = 1'b1;
            ram_rd_addr = ph_base + RAM_AW'(bin_of(div_quo[7:0]));
        end else if (state_reg == ST_BRD) begin
            ram_rd = 1'b1;
        end
    end

    assign ram_wr = state_reg == ST_WR;

    vdh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    vdh_ram #(
        .WIDTH (24),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (addr_reg),
        .wr_data (bin_inc),
        .rd_en   (ram_rd),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wiring_reg <= 1'b0;
            thr_reg    <= '0;
            nom_reg    <= NOMINAL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WIRING:  wiring_reg <= cfg_data[0];
                CFG_THRESH:  thr_reg    <= cfg_data[15:0];
                CFG_NOMINAL: nom_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    // sequencer and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            ph_reg    <= '0;
            idx_reg   <= '0;
            vld_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                min_reg[i] <= '0;
                max_reg[i] <= '0;
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
                flt_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        ph_reg <= phase_sel;
                        unique case (kind)
                            KIND_SAMPLE: begin
                                ph_reg    <= 2'd0;
                                state_reg <= ST_CHK;
                                for (int i = 0; i < 3; i++) begin
                                    if (st_v[i] > thr_reg) begin
                                        if (st_v[i] < min_reg[i] || min_reg[i] == 16'd0)
                                            min_reg[i] <= st_v[i];
                                        if (st_v[i] > max_reg[i])
                                            max_reg[i] <= st_v[i];
                                        if (cnt_reg[i] != SAT24) begin
                                            sum_reg[i] <= sum_reg[i] + {24'd0, st_v[i]};
                                            cnt_reg[i] <= cnt_reg[i] + 24'd1;
                                        end
                                    end
                                end
                            end
                            KIND_REPORT: begin
                                if (phase_sel != 2'd3) state_reg <= ST_MEAN;
                            end
                            KIND_CLEAR: begin
                                vld_reg <= '0;
                                for (int i = 0; i < 3; i++) begin
                                    min_reg[i] <= '0;
                                    max_reg[i] <= '0;
                                    sum_reg[i] <= '0;
                                    cnt_reg[i] <= '0;
                                    flt_reg[i] <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CHK: begin
                    if (cur_v > thr_reg) begin
                        state_reg <= ST_DIV;
                    end else begin
                        if (flt_reg[ph_reg] != SAT24)
                            flt_reg[ph_reg] <= flt_reg[ph_reg] + 24'd1;
                        if (ph_reg == 2'd2) state_reg <= ST_IDLE;
                        ph_reg <= ph_reg + 2'd1;
                    end
                end
                ST_DIV: begin
                    if (div_done) state_reg <= ST_WR;
                end
                ST_WR: begin
                    vld_reg[addr_reg] <= 1'b1;
                    state_reg <= (ph_reg == 2'd2) ? ST_IDLE : ST_CHK;
                    ph_reg    <= ph_reg + 2'd1;
                end
                ST_MEAN: begin
                    if (cnt_reg[ph_reg] == 24'd0 || div_done) state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    if (slot_free) begin
                        idx_reg   <= '0;
                        state_reg <= ST_BRD;
                    end
                end
                ST_BRD: begin
                    state_reg <= ST_BLD;
                end
                ST_BLD: begin
                    if (slot_free) begin
                        if (idx_reg == BIN_W'(BIN_COUNT - 1)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_BRD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_SAMPLE) begin
            vs_reg[0] <= volt_r;
            vs_reg[1] <= volt_s;
            vs_reg[2] <= volt_t;
        end
        if ((state_reg == ST_DIV && div_done) || state_reg == ST_BRD)
            addr_reg <= ram_rd_addr;
        if (state_reg == ST_MEAN)
            mean_reg <= (cnt_reg[ph_reg] == 24'd0) ? 16'd0 : div_quo[15:0];
    end

    // output register; a new transfer loads as soon as the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (slot_free) begin
            out_valid_reg <= state_reg == ST_SUM || state_reg == ST_BLD;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && state_reg == ST_SUM) begin
            is_summary_reg <= 1'b1;
            min_out_reg    <= min_reg[ph_reg];
            mean_out_reg   <= mean_reg;
            max_out_reg    <= max_reg[ph_reg];
            faults_out_reg <= flt_reg[ph_reg];
            bin_index_reg  <= '0;
            bin_value_reg  <= '0;
            last_reg       <= 1'b0;
        end else if (slot_free && state_reg == ST_BLD) begin
            is_summary_reg <= 1'b0;
            min_out_reg    <= '0;
            mean_out_reg   <= '0;
            max_out_reg    <= '0;
            faults_out_reg <= '0;
            bin_index_reg  <= 6'(idx_reg);
            bin_value_reg  <= bin_cur;
            last_reg       <= idx_reg == BIN_W'(BIN_COUNT - 1);
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_summary = is_summary_reg;
    assign min_volt   = min_out_reg;
    assign mean_volt  = mean_out_reg;
    assign max_volt   = max_out_reg;
    assign faults     = faults_out_reg;
    assign bin_index  = bin_index_reg;
    assign bin_value  = bin_value_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire
